>>> sv/itoa_pkg.sv
// Shared types, codes and helpers for the integer-to-ASCII converter.
// No dependencies; imported by the controller, datapath and top level.
package itoa_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 64;
	localparam int CHAR_W = 7;
	localparam int LEN_W = 5;

	localparam logic [1:0] OP_SDEC = 2'd0;
	localparam logic [1:0] OP_UDEC = 2'd1;
	localparam logic [1:0] OP_HEX  = 2'd2;
	localparam logic [1:0] OP_OCT  = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic conv_step;
		logic scan_step;
		logic scan_done;
		logic emit;
	} itoa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_dec;
		logic top_zero;
		logic one_digit;
		logic out_free;
		logic emit_last;
	} itoa_sts_t;

	// Digit slots: enough for decimal or octal text of a w-bit magnitude.
	function automatic int max_digits(input int w);
		int dec_n;
		int oct_n;
		dec_n = (w * 302) / 1000 + 1;
		oct_n = (w + 2) / 3;
		return (dec_n > oct_n) ? dec_n : oct_n;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_LOWA + {3'b000, d} - 7'd10;
		end
		return c;
	endfunction

endpackage

>>> sv/itoa_ctrl.sv
// Controller for the integer-to-ASCII converter: sequences load, binary
// to BCD conversion, leading-zero strip and character output. Uses itoa_pkg.
module itoa_ctrl
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  itoa_sts_t sts,
	output itoa_cmd_t cmd
);

	localparam int CNT_W = $clog2(VALUE_WIDTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					cnt_n    = CNT_W'(VALUE_WIDTH - 1);
					state_n  = sts.in_is_dec ? ST_CONV : ST_SCAN;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_SCAN;
				end else begin
					cnt_n = cnt_q - 1'b1;
				end
			end
			ST_SCAN: begin
				// drop leading zero digits, keep at least one
				if (sts.top_zero && !sts.one_digit) begin
					cmd.scan_step = 1'b1;
				end else begin
					cmd.scan_done = 1'b1;
					state_n       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

>>> sv/itoa_dp.sv
// Datapath for the integer-to-ASCII converter: magnitude and digit
// registers, shift-and-add-3 BCD step and the output register. Uses itoa_pkg.
module itoa_dp
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [63:0]       in_value,
	input  logic [1:0]        in_opcode,
	input  itoa_cmd_t         cmd,
	output itoa_sts_t         sts,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic [LEN_W-1:0]  out_len,
	output logic              out_last
);

	localparam int NDIG = max_digits(VALUE_WIDTH);
	localparam int DIG_W = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0]  mag_q;
	logic [NDIG-1:0][3:0]    dig_q;
	logic [DIG_W-1:0]        ndig_q;
	logic                    neg_q;
	logic [LEN_W-1:0]        len_q;

	logic                    out_valid_q;
	logic [CHAR_W-1:0]       out_char_q;
	logic [LEN_W-1:0]        out_len_q;
	logic                    out_last_q;

	logic [VALUE_WIDTH-1:0]  in_v;
	logic                    in_neg;
	logic [VALUE_WIDTH-1:0]  in_mag;
	logic [NDIG-1:0][3:0]    load_dig;
	logic [NDIG-1:0][3:0]    adj_dig;
	logic [NDIG-1:0][3:0]    conv_dig;
	logic [NDIG-1:0][3:0]    shift_dig;
	logic [VALUE_WIDTH-1:0]  sh_tmp;
	logic [CHAR_W-1:0]       cur_char;
	logic                    cur_last;

	assign in_v   = in_value[VALUE_WIDTH-1:0];
	assign in_neg = (in_opcode == OP_SDEC) && in_v[VALUE_WIDTH-1];
	assign in_mag = in_neg ? (~in_v + 1'b1) : in_v;

	// hex and octal digits are plain bit slices; decimal starts from zero
	always_comb begin
		load_dig = '0;
		sh_tmp   = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (in_opcode == OP_HEX) begin
				sh_tmp = in_v >> (4 * i);
				load_dig[i] = (4 * i < VALUE_WIDTH) ? sh_tmp[3:0] : 4'd0;
			end else if (in_opcode == OP_OCT) begin
				sh_tmp = in_v >> (3 * i);
				load_dig[i] = (3 * i < VALUE_WIDTH) ? {1'b0, sh_tmp[2:0]} : 4'd0;
			end
		end
	end

	// one shift-and-add-3 step: correct each BCD digit, then shift in one bit
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj_dig[i] = (dig_q[i] >= 4'd5) ? (dig_q[i] + 4'd3) : dig_q[i];
		end
		conv_dig[0] = {adj_dig[0][2:0], mag_q[VALUE_WIDTH-1]};
		for (int i = 1; i < NDIG; i++) begin
			conv_dig[i] = {adj_dig[i][2:0], adj_dig[i-1][3]};
		end
	end

	// advance one digit toward the top slot
	always_comb begin
		shift_dig[0] = 4'd0;
		for (int i = 1; i < NDIG; i++) begin
			shift_dig[i] = dig_q[i-1];
		end
	end

	assign cur_char = neg_q ? CHAR_MINUS : digit_char(dig_q[NDIG-1]);
	assign cur_last = !neg_q && (ndig_q == DIG_W'(1));

	assign sts.in_is_dec = !in_opcode[1];
	assign sts.top_zero  = (dig_q[NDIG-1] == 4'd0);
	assign sts.one_digit = (ndig_q == DIG_W'(1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.emit_last = cur_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q  <= in_mag;
			dig_q  <= load_dig;
			ndig_q <= DIG_W'(NDIG);
			neg_q  <= in_neg;
		end else if (cmd.conv_step) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			dig_q <= conv_dig;
		end else if (cmd.scan_step) begin
			dig_q  <= shift_dig;
			ndig_q <= ndig_q - 1'b1;
		end else if (cmd.scan_done) begin
			len_q <= LEN_W'(ndig_q) + LEN_W'(neg_q);
		end else if (cmd.emit) begin
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				dig_q  <= shift_dig;
				ndig_q <= ndig_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= cur_char;
			out_len_q  <= len_q;
			out_last_q <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_len   = out_len_q;
	assign out_last  = out_last_q;

endmodule

>>> sv/integer_to_ascii_digits.sv
// Top level of the integer-to-ASCII converter: stream ports around the
// controller (itoa_ctrl) and datapath (itoa_dp). Uses itoa_pkg.
//
// Usage: a request on the slave stream carries a value and an opcode
// (signed decimal, unsigned decimal, lowercase hex, octal). The master
// stream returns the text most significant character first, one character
// per transfer, each with the total text length; tlast marks the final one.
// Timing: one request at a time. Decimal requests pass each of the
// VALUE_WIDTH magnitude bits through the shift-and-add-3 loop; hex and octal
// skip it. Leading zero digits are then stripped one per cycle, the length
// is latched, and characters leave one per cycle unless m_tready stalls them.
// Strip plus emit always spans the NDIG digit slots (22 at the default
// width). A new request is taken once the last character is in the output
// register.
// Stall: a low m_tready holds the output register and the digit sequence.
// Reset: arst_n empties the output register and returns to idle.
module integer_to_ascii_digits
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] value, [65:64] opcode, [71:66] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] char_code, [11:7] text_length, [15:12] zero
	output logic        m_tlast
);

	itoa_cmd_t         cmd;
	itoa_sts_t         sts;
	logic [CHAR_W-1:0] out_char;
	logic [LEN_W-1:0]  out_len;

	itoa_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itoa_dp #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  (s_tdata[63:0]),
		.in_opcode (s_tdata[65:64]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_len   (out_len),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0000, out_len, out_char};

endmodule
